/* sv/tip_pkg.sv */
`default_nettype none

package tip_pkg;

   // Width of the vertex index ports
   localparam int VERTEX_BITS = 24;
   // Most results that one triangle can cause
   localparam int MAX_RESULTS = 6;
   // Group sizes
   localparam int SINGLE_COUNT = 3;
   localparam int PAIR_COUNT = 4;

   typedef logic [2:0] count_type;

   // Outcome of decoding one triangle against the pending one
   typedef struct packed {
      count_type count;
      logic      hold_store;
      logic      hold_valid;
   } plan_ctrl_type;

endpackage

`default_nettype wire

/* sv/tip_pair_decode.sv */
`default_nettype none

module tip_pair_decode #(
   parameter int IndexBits = 24
) (
   input  wire logic [2:0][IndexBits-1:0] held_tri,
   input  wire logic                      held_valid,
   input  wire logic [2:0][IndexBits-1:0] new_tri,
   input  wire logic                      last_tri,
   output      logic [tip_pkg::MAX_RESULTS-1:0][IndexBits-1:0] plan_index,
   output      tip_pkg::plan_ctrl_type    plan_ctrl
);
   import tip_pkg::*;

   typedef logic [2:0][IndexBits-1:0] tri_type;

   function automatic tri_type rotate(tri_type t);
      tri_type r;
      if (t[0] >= t[1]) begin
         r = t;
      end else if (t[1] >= t[2]) begin
         r[0] = t[1];
         r[1] = t[2];
         r[2] = t[0];
      end else begin
         r[0] = t[2];
         r[1] = t[0];
         r[2] = t[1];
      end
      return r;
   endfunction

   logic                 degenerate;
   logic                 found;
   logic [IndexBits-1:0] edge_a;
   logic [IndexBits-1:0] edge_b;
   logic [IndexBits-1:0] apex_c;
   logic [IndexBits-1:0] apex_d;
   tri_type              held_rot;
   tri_type              new_rot;

   assign degenerate = (held_tri[0] == held_tri[1]) || (held_tri[1] == held_tri[2]) ||
                       (held_tri[2] == held_tri[0]);
   assign held_rot = rotate(held_tri);
   assign new_rot  = rotate(new_tri);

   // First reversed edge wins: pending edges in order, then new positions
   always_comb begin
      found  = 1'b0;
      edge_a = held_tri[0];
      edge_b = held_tri[1];
      apex_c = held_tri[2];
      apex_d = new_tri[0];
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (!found && new_tri[j] == held_tri[(i + 1) % 3] &&
                new_tri[(j + 1) % 3] == held_tri[i]) begin
               found  = 1'b1;
               edge_a = held_tri[i];
               edge_b = held_tri[(i + 1) % 3];
               apex_c = held_tri[(i + 2) % 3];
               apex_d = new_tri[(j + 2) % 3];
            end
         end
      end
   end

   always_comb begin
      plan_index = '0;
      plan_ctrl  = '{count: '0, hold_store: 1'b0, hold_valid: 1'b0};
      priority if (!held_valid && !last_tri) begin
         plan_ctrl = '{count: '0, hold_store: 1'b1, hold_valid: 1'b1};
      end else if (!held_valid) begin
         plan_index[2:0] = new_rot;
         plan_ctrl.count = count_type'(SINGLE_COUNT);
      end else if (found && !degenerate) begin
         if (edge_a < edge_b) begin
            plan_index[0] = edge_a;
            plan_index[1] = edge_b;
            plan_index[2] = apex_c;
            plan_index[3] = apex_d;
         end else begin
            plan_index[0] = edge_b;
            plan_index[1] = edge_a;
            plan_index[2] = apex_d;
            plan_index[3] = apex_c;
         end
         plan_ctrl.count = count_type'(PAIR_COUNT);
      end else if (last_tri) begin
         plan_index[2:0] = held_rot;
         plan_index[5:3] = new_rot;
         plan_ctrl.count = count_type'(MAX_RESULTS);
      end else begin
         plan_index[2:0] = held_rot;
         plan_ctrl = '{count: count_type'(SINGLE_COUNT), hold_store: 1'b1, hold_valid: 1'b1};
      end
   end

endmodule

`default_nettype wire

/* sv/tip_out_serializer.sv */
`default_nettype none

module tip_out_serializer #(
   parameter int IndexBits = 24
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire logic [tip_pkg::MAX_RESULTS-1:0][IndexBits-1:0] load_index,
   input  wire tip_pkg::count_type   load_count,
   output      logic                 free,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      logic [tip_pkg::VERTEX_BITS-1:0] rsp_index_value,
   output      logic                 rsp_group_start,
   output      logic                 rsp_run_end
);
   import tip_pkg::*;

   logic [MAX_RESULTS-1:0][IndexBits-1:0] index_ff;
   count_type                             count_ff;
   count_type                             pos_ff;
   count_type                             pos_in;
   logic                                  valid_ff;
   logic                                  valid_in;
   logic                                  xfer;
   logic                                  last_pos;

   assign last_pos = (pos_ff == count_ff - count_type'(1));
   assign xfer     = valid_ff && rsp_ready;
   assign free     = !valid_ff || (xfer && last_pos);

   assign rsp_valid       = valid_ff;
   assign rsp_index_value = VERTEX_BITS'(index_ff[pos_ff]);
   assign rsp_group_start = (pos_ff == '0) ||
                            (pos_ff == count_type'(SINGLE_COUNT) &&
                             count_ff == count_type'(MAX_RESULTS));
   assign rsp_run_end     = last_pos;

   always_comb begin
      valid_in = valid_ff;
      pos_in   = pos_ff;
      priority if (load) begin
         valid_in = 1'b1;
         pos_in   = '0;
      end else if (xfer && last_pos) begin
         valid_in = 1'b0;
      end else if (xfer) begin
         pos_in = pos_ff + count_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         index_ff <= load_index;
         count_ff <= load_count;
      end
   end

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (pos_ff < count_ff))
      else $error("result position beyond group count");

   a_count_legal: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (count_ff == count_type'(SINGLE_COUNT) ||
                    count_ff == count_type'(PAIR_COUNT) ||
                    count_ff == count_type'(MAX_RESULTS)))
      else $error("illegal result count");

   a_load_only_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("plan loaded over results not yet delivered");

endmodule

`default_nettype wire

/* sv/paired_triangle_index_packer.sv */
// Path: an item is taken into the input register on transfer; it moves on when the
//   serializer is free, and its first index is then offered on rsp from the result register.
// Throughput: one index per cycle on rsp while rsp_ready is high; an item causes 3, 4
//   or 6 indices, or none, and the input register takes a new item while they drain.
// Reset: synchronous, active high; clears the pending flag and all valid state.
`default_nettype none

module paired_triangle_index_packer #(
   parameter int INDEX_BITS = 24
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic [tip_pkg::VERTEX_BITS-1:0] req_vertex_a,
   input  wire logic [tip_pkg::VERTEX_BITS-1:0] req_vertex_b,
   input  wire logic [tip_pkg::VERTEX_BITS-1:0] req_vertex_c,
   input  wire logic                            req_final_tri,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic [tip_pkg::VERTEX_BITS-1:0] rsp_index_value,
   output      logic                            rsp_group_start,
   output      logic                            rsp_run_end
);
   import tip_pkg::*;

   localparam int KeepBits = (INDEX_BITS < VERTEX_BITS) ? INDEX_BITS : VERTEX_BITS;

   logic [2:0][KeepBits-1:0] in_tri_ff;
   logic                     in_last_ff;
   logic                     in_valid_ff;
   logic                     in_valid_in;
   logic [2:0][KeepBits-1:0] held_ff;
   logic                     held_valid_ff;
   logic                     held_valid_in;
   logic                     in_move;
   logic                     plan_free;
   logic                     req_xfer;

   logic [MAX_RESULTS-1:0][KeepBits-1:0] plan_index;
   plan_ctrl_type                        plan_ctrl;

   assign in_move   = in_valid_ff && plan_free;
   assign req_ready = !in_valid_ff || in_move;
   assign req_xfer  = req_valid && req_ready;

   assign in_valid_in   = req_xfer ? 1'b1 : (in_move ? 1'b0 : in_valid_ff);
   assign held_valid_in = in_move ? plan_ctrl.hold_valid : held_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         held_valid_ff <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         held_valid_ff <= held_valid_in;
      end
   end

   // Drop index bits above the configured width
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_tri_ff[0] <= req_vertex_a[KeepBits-1:0];
         in_tri_ff[1] <= req_vertex_b[KeepBits-1:0];
         in_tri_ff[2] <= req_vertex_c[KeepBits-1:0];
         in_last_ff   <= req_final_tri;
      end
      if (in_move && plan_ctrl.hold_store) begin
         held_ff <= in_tri_ff;
      end
   end

   tip_pair_decode #(
      .IndexBits (KeepBits)
   ) u_decode (
      .held_tri   (held_ff),
      .held_valid (held_valid_ff),
      .new_tri    (in_tri_ff),
      .last_tri   (in_last_ff),
      .plan_index (plan_index),
      .plan_ctrl  (plan_ctrl)
   );

   tip_out_serializer #(
      .IndexBits (KeepBits)
   ) u_serializer (
      .clock           (clock),
      .reset           (reset),
      .load            (in_move && (plan_ctrl.count != '0)),
      .load_index      (plan_index),
      .load_count      (plan_ctrl.count),
      .free            (plan_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_index_value (rsp_index_value),
      .rsp_group_start (rsp_group_start),
      .rsp_run_end     (rsp_run_end)
   );

   a_final_flushes: assert property (@(posedge clock) disable iff (reset)
      (in_move && in_last_ff) |=> !held_valid_ff)
      else $error("pending triangle kept after final triangle");

   a_store_sets_pending: assert property (@(posedge clock) disable iff (reset)
      (in_move && plan_ctrl.hold_store) |=> held_valid_ff)
      else $error("stored triangle not marked pending");

   a_silent_only_when_storing: assert property (@(posedge clock) disable iff (reset)
      (in_move && plan_ctrl.count == '0) |-> (!held_valid_ff && !in_last_ff))
      else $error("item dropped without results");

endmodule

`default_nettype wire
